### hw/rtl/gelu_pkg.sv
package gelu_pkg;

	parameter int unsigned FRAC_BITS_DEF      = 12;
	parameter int unsigned TABLE_SEGMENTS_DEF = 256;

	localparam int unsigned X_W   = 16;
	localparam int unsigned MAG_W = X_W + 1;
	localparam int unsigned PHI_W = 25;

	localparam logic [PHI_W-1:0] PHI_ONE = 25'h100_0000;

	localparam logic [63:0] Q30_ONE          = 64'd1 << 30;
	localparam logic [63:0] INV_SQRT_2PI_Q30 = 64'd428361012;
	localparam logic [63:0] PHI_ONE_Q24      = 64'd1 << 24;

	// Normal CDF at t = 4*K/Segs in Q1.24. Evaluated only while elaborating
	// the table; the Gaussian comes from an exp(-e) power recurrence and the
	// erf factor from its odd power series.
	function automatic logic [PHI_W-1:0] phi_rom_entry(input int unsigned Segs,
			input int unsigned K);
		logic [63:0] s;
		logic [63:0] e;
		logic [63:0] q;
		logic [63:0] term;
		logic [63:0] q2;
		logic [63:0] pw;
		logic [63:0] g;
		logic [63:0] phi;
		logic [63:0] sum;
		logic [63:0] t;
		logic [63:0] prod;
		logic [63:0] val;
		logic [63:0] Den;
		logic [63:0] N;
		logic [63:0] kk;
		int unsigned n;
		int unsigned j;
		int unsigned i;
		s    = 64'(Segs);
		kk   = 64'(K);
		Den  = s * s;
		e    = (64'd8 << 30) / Den;
		q    = Q30_ONE;
		term = Q30_ONE;
		for (n = 1; n <= 6; n++) begin
			N    = 64'(n);
			term = ((term * e) >> 30) / N;
			if (N[0]) begin
				q = q - term;
			end else begin
				q = q + term;
			end
		end
		q2 = (q * q) >> 30;
		pw = q;
		g  = Q30_ONE;
		for (j = 1; j <= K; j++) begin
			g  = (g * pw) >> 30;
			pw = (pw * q2) >> 30;
		end
		phi = (g * INV_SQRT_2PI_Q30) >> 30;
		Den = s;
		t   = ((64'd4 * kk) << 28) / Den;
		sum = 64'd0;
		for (i = 0; i < 256 && t != 64'd0; i++) begin
			sum = sum + t;
			Den = s * s * (64'd2 * 64'(i) + 64'd3);
			t   = (t * 64'd16 * kk * kk) / Den;
		end
		prod = phi * (sum >> 8);
		val  = ((prod + (64'd1 << 25)) >> 26) + (64'd1 << 23);
		if (val > PHI_ONE_Q24) begin
			val = PHI_ONE_Q24;
		end
		return val[PHI_W-1:0];
	endfunction

endpackage

### hw/rtl/gelu_in_if.sv
interface gelu_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [gelu_pkg::X_W-1:0]    x;
	logic                               last_in;

	modport source (output valid, output x, output last_in, input ready);
	modport sink   (input valid, input x, input last_in, output ready);
endinterface

### hw/rtl/gelu_out_if.sv
interface gelu_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [gelu_pkg::X_W-1:0]    y;
	logic                               last_out;

	modport source (output valid, output y, output last_out, input ready);
	modport sink   (input valid, input y, input last_out, output ready);
endinterface

### hw/rtl/gelu_activation_top.sv
// Exact GELU on a sample stream, one request accepted per clock when not stalled.
// Samples pass from stage 1 to stage 7 in order; stage 7 holds the output register.
// Throughput is one sample per cycle while the output is not stalled, set by the seven-stage
// pipeline with a per-stage ready chain, so bubbles are squeezed out while the output stalls.
// Reset (arst_n low, asynchronous) empties every stage; the CDF table is constant.
module gelu_activation_top #(
	parameter int unsigned FRAC_BITS      = gelu_pkg::FRAC_BITS_DEF,
	parameter int unsigned TABLE_SEGMENTS = gelu_pkg::TABLE_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gelu_in_if.sink     samples,
	gelu_out_if.source  results
);

	localparam int unsigned SH    = FRAC_BITS + 2;
	localparam int unsigned IDXW  = $clog2(TABLE_SEGMENTS + 1);
	localparam int unsigned MAG_W = gelu_pkg::MAG_W;
	localparam int unsigned PHI_W = gelu_pkg::PHI_W;
	localparam int unsigned PW    = (MAG_W + IDXW > SH + IDXW + 1) ?
		(MAG_W + IDXW) : (SH + IDXW + 1);
	localparam int unsigned DW    = PHI_W + SH;
	localparam int unsigned PRW   = MAG_W + PHI_W;
	localparam logic [PW-1:0] SEG_P = PW'(TABLE_SEGMENTS);

	// Constant CDF table, one point per segment boundary.
	logic [PHI_W-1:0] rom_c [TABLE_SEGMENTS+1];

	for (genvar k = 0; k <= TABLE_SEGMENTS; k++) begin : g_rom
		assign rom_c[k] = gelu_pkg::phi_rom_entry(TABLE_SEGMENTS, k);
	end

	// Valid bits and stage enables.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || results.ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign samples.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= samples.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// Stage 1: sign and magnitude.
	logic             neg_s1, last_s1;
	logic [MAG_W-1:0] a_s1;
	logic [MAG_W-1:0] x_ext_c;

	assign x_ext_c = {1'b0, samples.x};

	// Stage 2: table position.
	logic             neg_s2, last_s2, sat_s2;
	logic [MAG_W-1:0] a_s2;
	logic [IDXW-1:0]  idx_s2;
	logic [SH-1:0]    frac_s2;
	logic [PW-1:0]    pos_c;
	logic [PW-1:0]    idx_full_c;

	assign pos_c      = PW'(a_s1) * SEG_P;
	assign idx_full_c = pos_c >> SH;

	// Stage 3: the two neighbouring table points.
	logic             neg_s3, last_s3, sat_s3;
	logic [MAG_W-1:0] a_s3;
	logic [SH-1:0]    frac_s3;
	logic [PHI_W-1:0] lo_s3, hi_s3;
	logic [IDXW-1:0]  idx_nx_c;

	assign idx_nx_c = idx_s2 + IDXW'(1);

	// Stage 4: slope times fraction.
	logic             neg_s4, last_s4, sat_s4, up_s4;
	logic [MAG_W-1:0] a_s4;
	logic [PHI_W-1:0] lo_s4;
	logic [DW-1:0]    step_s4;
	logic             up_c;
	logic [PHI_W-1:0] diff_c;

	assign up_c   = hi_s3 >= lo_s3;
	assign diff_c = up_c ? (hi_s3 - lo_s3) : (lo_s3 - hi_s3);

	// Stage 5: interpolated CDF with symmetry for negative samples.
	logic             neg_s5, last_s5;
	logic [MAG_W-1:0] a_s5;
	logic [PHI_W-1:0] phi_s5;
	logic [PHI_W-1:0] step_c;
	logic [PHI_W-1:0] phi_pos_c;

	assign step_c = PHI_W'(step_s4 >> SH);

	always_comb begin
		if (sat_s4) begin
			phi_pos_c = gelu_pkg::PHI_ONE;
		end else if (up_s4) begin
			phi_pos_c = lo_s4 + step_c;
		end else begin
			phi_pos_c = lo_s4 - step_c;
		end
	end

	// Stage 6: magnitude times CDF.
	logic             neg_s6, last_s6;
	logic [PRW-1:0]   prod_s6;

	// Stage 7: rounding and sign, held as the output register.
	logic                          last_s7;
	logic [gelu_pkg::X_W-1:0]      y_s7;
	logic [PRW:0]                  rnd_c;
	logic [gelu_pkg::X_W-1:0]      mag_c;

	// Ties round away from zero because the sign is applied after rounding.
	assign rnd_c = {1'b0, prod_s6} + (PRW+1)'(1 << 23);
	assign mag_c = rnd_c[24 +: gelu_pkg::X_W];

	always_ff @(posedge clk) begin
		if (en1) begin
			neg_s1  <= samples.x[gelu_pkg::X_W-1];
			a_s1    <= samples.x[gelu_pkg::X_W-1] ? (MAG_W'(1 << 16) - x_ext_c) : x_ext_c;
			last_s1 <= samples.last_in;
		end
		if (en2) begin
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
			a_s2    <= a_s1;
			sat_s2  <= idx_full_c >= SEG_P;
			idx_s2  <= (idx_full_c >= SEG_P) ? '0 : idx_full_c[IDXW-1:0];
			frac_s2 <= pos_c[SH-1:0];
		end
		if (en3) begin
			neg_s3  <= neg_s2;
			last_s3 <= last_s2;
			sat_s3  <= sat_s2;
			a_s3    <= a_s2;
			frac_s3 <= frac_s2;
			lo_s3   <= rom_c[idx_s2];
			hi_s3   <= rom_c[idx_nx_c];
		end
		if (en4) begin
			neg_s4  <= neg_s3;
			last_s4 <= last_s3;
			sat_s4  <= sat_s3;
			a_s4    <= a_s3;
			lo_s4   <= lo_s3;
			up_s4   <= up_c;
			step_s4 <= DW'(diff_c) * DW'(frac_s3);
		end
		if (en5) begin
			neg_s5  <= neg_s4;
			last_s5 <= last_s4;
			a_s5    <= a_s4;
			phi_s5  <= neg_s4 ? (gelu_pkg::PHI_ONE - phi_pos_c) : phi_pos_c;
		end
		if (en6) begin
			neg_s6  <= neg_s5;
			last_s6 <= last_s5;
			prod_s6 <= PRW'(a_s5) * PRW'(phi_s5);
		end
		if (en7) begin
			last_s7 <= last_s6;
			y_s7    <= neg_s6 ? (gelu_pkg::X_W'(0) - mag_c) : mag_c;
		end
	end

	assign results.valid    = v_s7;
	assign results.y        = y_s7;
	assign results.last_out = last_s7;

endmodule
